// ----- design/assert_macros.svh -----
// Assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define BGC_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset
`define BGC_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ----- design/bgc_pkg.sv -----
// Package: types, constants and event codes of the button gesture classifier
`timescale 1ns / 1ps
package bgc_pkg;

   localparam int TIME_W     = 32;
   localparam int EVENT_W    = 4;
   localparam int CLICK_W    = 8;
   localparam int HOLDS_W    = 16;
   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam int BGC_QUEUE_DEPTH = 4;

   // Event codes
   localparam logic [EVENT_W-1:0] EV_PRESS      = 4'd0;
   localparam logic [EVENT_W-1:0] EV_RELEASE    = 4'd1;
   localparam logic [EVENT_W-1:0] EV_CHANGE     = 4'd2;
   localparam logic [EVENT_W-1:0] EV_HOLD       = 4'd3;
   localparam logic [EVENT_W-1:0] EV_CLICK_BASE = 4'd3;  // click_n = base + n
   localparam logic [EVENT_W-1:0] EV_CRAZY      = 4'd14;

   localparam logic [CLICK_W-1:0] CRAZY_COUNT = 8'd10;
   localparam logic [CLICK_W-1:0] CLICK_MAX   = 8'hFF;
   localparam logic [HOLDS_W-1:0] HOLDS_MAX   = 16'hFFFF;

   // Register indexes (byte address / 4)
   localparam logic [1:0] REG_HOLD_TIME    = 2'd0;
   localparam logic [1:0] REG_REPEAT_HOLD  = 2'd1;
   localparam logic [1:0] REG_MULTI_WINDOW = 2'd2;
   localparam logic [1:0] REG_BISTABLE     = 2'd3;

   typedef struct packed {
      logic [TIME_W-1:0] hold_time_ms;
      logic [TIME_W-1:0] repeat_hold_ms;
      logic [TIME_W-1:0] multiclick_window_ms;
      logic              bistable_mode;
   } bgc_cfg_type;

   // Events produced by one tick, pushed into the result queue together
   typedef struct packed {
      logic [1:0]         count;
      logic [EVENT_W-1:0] code0;
      logic [EVENT_W-1:0] code1;
   } bgc_push_type;

endpackage

// ----- design/bgc_if.sv -----
// Channel interfaces: tick input and event result
`timescale 1ns / 1ps
interface bgc_req_if;
   import bgc_pkg::*;
   logic              valid;
   logic              ready;
   logic              level_pressed;
   logic [TIME_W-1:0] now_ms;

   modport source (output valid, level_pressed, now_ms, input ready);
   modport sink   (input valid, level_pressed, now_ms, output ready);
endinterface

interface bgc_rsp_if;
   import bgc_pkg::*;
   logic               valid;
   logic               ready;
   logic [EVENT_W-1:0] event_code;
   logic               last_of_run;

   modport source (output valid, event_code, last_of_run, input ready);
   modport sink   (input valid, event_code, last_of_run, output ready);
endinterface

// ----- design/bgc_csr.sv -----
// Configuration registers behind the APB-style port
`timescale 1ns / 1ps
module bgc_csr (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [bgc_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [bgc_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [bgc_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready,
   output bgc_pkg::bgc_cfg_type           cfg
);
   import bgc_pkg::*;

   bgc_cfg_type cfg_ff;
   bgc_cfg_type cfg_in;
   logic        wr_en;
   logic [1:0]  reg_idx;

   assign pready  = 1'b1;
   assign wr_en   = psel && penable && pwrite;
   assign reg_idx = paddr[3:2];
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_idx)
            REG_HOLD_TIME:    cfg_in.hold_time_ms         = pwdata;
            REG_REPEAT_HOLD:  cfg_in.repeat_hold_ms       = pwdata;
            REG_MULTI_WINDOW: cfg_in.multiclick_window_ms = pwdata;
            REG_BISTABLE:     cfg_in.bistable_mode        = pwdata[0];
         endcase
      end
   end

   always_comb begin
      unique case (reg_idx)
         REG_HOLD_TIME:    prdata = cfg_ff.hold_time_ms;
         REG_REPEAT_HOLD:  prdata = cfg_ff.repeat_hold_ms;
         REG_MULTI_WINDOW: prdata = cfg_ff.multiclick_window_ms;
         REG_BISTABLE:     prdata = {{(CSR_DATA_W-1){1'b0}}, cfg_ff.bistable_mode};
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ----- design/bgc_core.sv -----
// Tick input register, gesture state and event classification
`timescale 1ns / 1ps
module bgc_core (
   input  logic                       clock,
   input  logic                       reset,
   input  bgc_pkg::bgc_cfg_type       cfg,
   input  logic                       req_valid,
   output logic                       req_ready,
   input  logic                       req_level_pressed,
   input  logic [bgc_pkg::TIME_W-1:0] req_now_ms,
   input  logic                       queue_room,
   output bgc_pkg::bgc_push_type      push
);
   import bgc_pkg::*;

   // input register
   logic              stg_valid_ff, stg_valid_in;
   logic              stg_level_ff;
   logic [TIME_W-1:0] stg_now_ff;

   // gesture state
   logic               prev_level_ff, prev_level_in;
   logic [TIME_W-1:0]  last_change_ff, last_change_in;
   logic [CLICK_W-1:0] click_count_ff, click_count_in;
   logic [HOLDS_W-1:0] holds_sent_ff, holds_sent_in;

   logic                       fire;
   logic                       req_xfer;
   logic [TIME_W-1:0]          elapsed;
   logic [TIME_W+HOLDS_W-1:0]  hold_prod;
   logic [TIME_W+HOLDS_W:0]    hold_thr;
   logic                       hold_allowed;
   logic                       changed;
   bgc_push_type               push_w;

   assign fire      = stg_valid_ff && queue_room;
   assign req_ready = !stg_valid_ff || queue_room;
   assign req_xfer  = req_valid && req_ready;

   assign elapsed   = stg_now_ff - last_change_ff;
   assign changed   = stg_level_ff != prev_level_ff;
   assign hold_prod = holds_sent_ff * cfg.repeat_hold_ms;
   assign hold_thr  = {1'b0, hold_prod} + {{(HOLDS_W+1){1'b0}}, cfg.hold_time_ms};
   assign hold_allowed = (cfg.repeat_hold_ms == '0) ? (holds_sent_ff == '0) : 1'b1;

   always_comb begin
      push_w         = '0;
      prev_level_in  = prev_level_ff;
      last_change_in = last_change_ff;
      click_count_in = click_count_ff;
      holds_sent_in  = holds_sent_ff;

      priority if (changed) begin
         push_w.count   = 2'd2;
         push_w.code0   = stg_level_ff ? EV_PRESS : EV_RELEASE;
         push_w.code1   = EV_CHANGE;
         prev_level_in  = stg_level_ff;
         last_change_in = stg_now_ff;
         if ((stg_level_ff || cfg.bistable_mode) && click_count_ff != CLICK_MAX)
            click_count_in = click_count_ff + 1'b1;
      end else if (!cfg.bistable_mode && stg_level_ff) begin
         if (click_count_ff <= 8'd1 && cfg.hold_time_ms != '0 &&
             {{(HOLDS_W+1){1'b0}}, elapsed} > hold_thr && hold_allowed) begin
            push_w.count = 2'd1;
            push_w.code0 = EV_HOLD;
            if (holds_sent_ff != HOLDS_MAX)
               holds_sent_in = holds_sent_ff + 1'b1;
         end
      end else if (click_count_ff != '0) begin
         if (cfg.multiclick_window_ms == '0) begin
            click_count_in = '0;
            holds_sent_in  = '0;
         end else if (elapsed > cfg.multiclick_window_ms) begin
            if (holds_sent_ff == '0) begin
               priority if (click_count_ff < CRAZY_COUNT) begin
                  push_w.count = 2'd1;
                  push_w.code0 = EV_CLICK_BASE + click_count_ff[EVENT_W-1:0];
               end else if (click_count_ff == CRAZY_COUNT) begin
                  push_w.count = 2'd2;
                  push_w.code0 = EV_CLICK_BASE + click_count_ff[EVENT_W-1:0];
                  push_w.code1 = EV_CRAZY;
               end else begin
                  push_w.count = 2'd1;
                  push_w.code0 = EV_CRAZY;
               end
            end
            click_count_in = '0;
            holds_sent_in  = '0;
         end
      end else begin
         // no change, no hold check and no open series: no event
         push_w.count = 2'd0;
      end
   end

   always_comb begin
      push = push_w;
      if (!fire) push.count = 2'd0;
   end

   always_comb begin
      stg_valid_in = stg_valid_ff;
      if (req_xfer)  stg_valid_in = 1'b1;
      else if (fire) stg_valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (req_xfer) begin
         stg_level_ff <= req_level_pressed;
         stg_now_ff   <= req_now_ms;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stg_valid_ff   <= 1'b0;
         prev_level_ff  <= 1'b0;
         last_change_ff <= '0;
         click_count_ff <= '0;
         holds_sent_ff  <= '0;
      end else begin
         stg_valid_ff <= stg_valid_in;
         if (fire) begin
            prev_level_ff  <= prev_level_in;
            last_change_ff <= last_change_in;
            click_count_ff <= click_count_in;
            holds_sent_ff  <= holds_sent_in;
         end
      end
   end

endmodule

// ----- design/bgc_result_queue.sv -----
// Result queue: takes up to two events a cycle, hands out one per transfer
`timescale 1ns / 1ps
module bgc_result_queue #(
   parameter int Depth = bgc_pkg::BGC_QUEUE_DEPTH
) (
   input  logic                        clock,
   input  logic                        reset,
   input  bgc_pkg::bgc_push_type       push,
   output logic                        room,
   output logic                        out_valid,
   input  logic                        out_ready,
   output logic [bgc_pkg::EVENT_W-1:0] out_code,
   output logic                        out_last
);
   import bgc_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);
   localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
   localparam logic [CntW-1:0] RoomMax = CntW'(Depth - 2);

   logic [EVENT_W-1:0] code_ff [Depth];
   logic               last_ff [Depth];
   logic [PtrW-1:0]    rptr_ff, rptr_in;
   logic [PtrW-1:0]    wptr_ff, wptr_in;
   logic [PtrW-1:0]    wptr_nxt;
   logic [CntW-1:0]    count_ff, count_in;
   logic               pop;

   function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
      return (p == PtrLast) ? '0 : p + 1'b1;
   endfunction

   assign out_valid = count_ff != '0;
   assign out_code  = code_ff[rptr_ff];
   assign out_last  = last_ff[rptr_ff];
   assign pop       = out_valid && out_ready;
   assign room      = count_ff <= RoomMax;
   assign wptr_nxt  = ptr_inc(wptr_ff);

   always_comb begin
      rptr_in  = pop ? ptr_inc(rptr_ff) : rptr_ff;
      count_in = count_ff + CntW'(push.count) - CntW'(pop);
      unique case (push.count)
         2'd0:    wptr_in = wptr_ff;
         2'd1:    wptr_in = wptr_nxt;
         default: wptr_in = ptr_inc(wptr_nxt);
      endcase
   end

   always_ff @(posedge clock) begin
      if (push.count != 2'd0) begin
         code_ff[wptr_ff] <= push.code0;
         last_ff[wptr_ff] <= push.count == 2'd1;
      end
      if (push.count == 2'd2) begin
         code_ff[wptr_nxt] <= push.code1;
         last_ff[wptr_nxt] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rptr_ff  <= '0;
         wptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         rptr_ff  <= rptr_in;
         wptr_ff  <= wptr_in;
         count_ff <= count_in;
      end
   end

endmodule

// ----- design/button_gesture_classifier_top.sv -----
// Top level of the button gesture classifier
`timescale 1ns / 1ps
// Button gesture classifier.
// req_chan carries one tick per transfer: debounced level and millisecond time.
// rsp_chan returns the events of each tick in order (press/release + change,
// hold, click_1..click_10, crazy_clicker); last_of_run marks a tick's final
// event. Ticks that cause no event produce no transfer on rsp_chan.
// csr_* is an APB-style port; registers at byte 0 hold_time_ms, 4 repeat_hold_ms,
// 8 multiclick_window_ms, 12 bistable_mode. Write only while idle.
// Path: a tick is held in the input register, classified from there, and its
// events are written into the result queue, from which rsp_chan offers them.
// Throughput: one tick per cycle while the queue has room, set by the input
// register feeding the classifier; output drains one event per cycle from a
// small result queue, so a sustained stream of two-event ticks is output-bound.
// When rsp_chan stalls, the queue fills; the classifier waits once fewer than
// two slots are free; then req_chan.ready drops once the input register is full.
// Reset (synchronous, active high) clears registers, gesture state and queue.
module button_gesture_classifier_top #(
   parameter int QueueDepth = bgc_pkg::BGC_QUEUE_DEPTH
) (
   input  logic                           clock,
   input  logic                           reset,
   bgc_req_if.sink                        req_chan,
   bgc_rsp_if.source                      rsp_chan,
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [bgc_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [bgc_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [bgc_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                           csr_pready
);
   import bgc_pkg::*;

   bgc_cfg_type  cfg;
   bgc_push_type push;
   logic         queue_room;

   bgc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (csr_psel),
      .penable (csr_penable),
      .pwrite  (csr_pwrite),
      .paddr   (csr_paddr),
      .pwdata  (csr_pwdata),
      .prdata  (csr_prdata),
      .pready  (csr_pready),
      .cfg     (cfg)
   );

   // tick register + classifier; pushes up to two events per transfer
   bgc_core u_core (
      .clock             (clock),
      .reset             (reset),
      .cfg               (cfg),
      .req_valid         (req_chan.valid),
      .req_ready         (req_chan.ready),
      .req_level_pressed (req_chan.level_pressed),
      .req_now_ms        (req_chan.now_ms),
      .queue_room        (queue_room),
      .push              (push)
   );

   bgc_result_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .room      (queue_room),
      .out_valid (rsp_chan.valid),
      .out_ready (rsp_chan.ready),
      .out_code  (rsp_chan.event_code),
      .out_last  (rsp_chan.last_of_run)
   );

endmodule

// ----- design/bgc_checker.sv -----
// Port-level checker for the result channel, bound to the top level
`timescale 1ns / 1ps
`include "assert_macros.svh"
module bgc_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [bgc_pkg::EVENT_W-1:0] rsp_event_code,
   input logic                        rsp_last_of_run
);
   import bgc_pkg::*;

   `BGC_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_event_code) && $stable(rsp_last_of_run), "stalled result changed")

   `BGC_ASSERT_NEXT(a_run_continues, clock, reset, rsp_valid && rsp_ready && !rsp_last_of_run, rsp_valid, "tick's event run broken")

   `BGC_ASSERT_NOW(a_edge_not_last, clock, reset, rsp_valid && (rsp_event_code == EV_PRESS || rsp_event_code == EV_RELEASE), !rsp_last_of_run, "press/release ended run")

   `BGC_ASSERT_NOW(a_change_last, clock, reset, rsp_valid && rsp_event_code == EV_CHANGE, rsp_last_of_run, "change not last of run")

endmodule

bind button_gesture_classifier_top bgc_checker u_bgc_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_chan.valid),
   .rsp_ready       (rsp_chan.ready),
   .rsp_event_code  (rsp_chan.event_code),
   .rsp_last_of_run (rsp_chan.last_of_run)
);

// ----- bench/tb_button_gesture_classifier_top.sv -----
// Self-checking testbench for button_gesture_classifier_top: directed and random ticks
`timescale 1ns / 1ps
module tb_button_gesture_classifier_top;
   import bgc_pkg::*;

   localparam int WATCHDOG_LIMIT = 2000;  // cycles with no transfer at all
   localparam int SETTLE_CYCLES  = 8;     // margin after the drain, for ticks that cause no event
   localparam int MAX_REPORTS    = 10;

   // One expected event on rsp_chan
   typedef struct {
      logic [EVENT_W-1:0] code;
      logic               last_of_run;
   } gesture_event_type;

   logic clock;
   logic reset;

   bgc_req_if req_chan ();
   bgc_rsp_if rsp_chan ();

   logic                  csr_psel;
   logic                  csr_penable;
   logic                  csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   button_gesture_classifier_top DUT (
      .clock      (clock),
      .reset      (reset),
      .req_chan   (req_chan),
      .rsp_chan   (rsp_chan),
      .csr_psel   (csr_psel),
      .csr_penable(csr_penable),
      .csr_pwrite (csr_pwrite),
      .csr_paddr  (csr_paddr),
      .csr_pwdata (csr_pwdata),
      .csr_prdata (csr_prdata),
      .csr_pready (csr_pready)
   );

   // Predictor copy of the registers and the gesture state
   bgc_cfg_type          cfg         = '0;
   logic                 seen_level  = 1'b0;
   logic [TIME_W-1:0]    change_ms   = '0;
   logic [CLICK_W-1:0]   click_tally = '0;
   logic [HOLDS_W-1:0]   hold_tally  = '0;

   gesture_event_type    pending_events[$];   // events predicted, not yet seen
   logic [TIME_W-1:0]    sim_ms;              // running millisecond time
   int unsigned          ticks_sent      = 0;
   int                   sender_idle_pct = 0;
   int                   reply_stall_pct = 0;
   int                   holdoff_left    = 0; // long receiver stall, cycles
   int                   mismatch_count  = 0;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // Predictor: events caused by one accepted tick, in order
   // ---------------------------------------------------------------------------
   task automatic classify_tick(input logic level, input logic [TIME_W-1:0] now);
      logic [TIME_W-1:0]  elapsed;
      logic [63:0]        threshold;
      logic [EVENT_W-1:0] codes[$];
      // quiet time measured against the previous change, before this tick's update
      elapsed = now - change_ms;
      if (level != seen_level) begin
         codes.push_back(level ? EV_PRESS : EV_RELEASE);
         codes.push_back(EV_CHANGE);
         seen_level = level;
         change_ms  = now;
         if ((level || cfg.bistable_mode) && click_tally != CLICK_MAX)
            click_tally++;
      end else if (!cfg.bistable_mode && level) begin
         // threshold formed in 64 bits: a sum past 2^32 can never be reached
         threshold = 64'(cfg.hold_time_ms) + 64'(hold_tally) * 64'(cfg.repeat_hold_ms);
         if (click_tally <= 1 && cfg.hold_time_ms != 0 && 64'(elapsed) > threshold &&
             (cfg.repeat_hold_ms != 0 || hold_tally == 0)) begin
            codes.push_back(EV_HOLD);
            if (hold_tally != HOLDS_MAX)
               hold_tally++;
         end
      end else if (click_tally != 0) begin
         if (cfg.multiclick_window_ms == 0) begin
            // no click events at all: series dropped every quiet tick
            hold_tally  = '0;
            click_tally = '0;
         end else if (elapsed > cfg.multiclick_window_ms) begin
            // a series that saw a hold ends silently
            if (hold_tally == 0) begin
               if (click_tally <= CRAZY_COUNT)
                  codes.push_back(EV_CLICK_BASE + click_tally[EVENT_W-1:0]);
               if (click_tally >= CRAZY_COUNT)
                  codes.push_back(EV_CRAZY);
            end
            hold_tally  = '0;
            click_tally = '0;
         end
      end
      foreach (codes[i])
         pending_events.push_back('{code: codes[i], last_of_run: (i == codes.size() - 1)});
   endtask

   // ---------------------------------------------------------------------------
   // Stimulus side
   // ---------------------------------------------------------------------------

   // Advance time by step_ms and offer one tick; returns at the transfer edge
   // with valid still high, so back-to-back ticks keep it asserted.
   task automatic send_tick(input logic level, input logic [TIME_W-1:0] step_ms);
      sim_ms += step_ms;
      if (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct) begin
         req_chan.valid <= 1'b0;
         do @(posedge clock); while ($urandom_range(99) < sender_idle_pct);
      end
      req_chan.valid         <= 1'b1;
      req_chan.level_pressed <= level;
      req_chan.now_ms        <= sim_ms;
      do @(posedge clock); while (!req_chan.ready);
      classify_tick(level, sim_ms);
      ticks_sent++;
   endtask

   // Stop offering ticks and let every expected event drain, plus a margin for
   // ticks that cause no event but may still be in flight.
   task automatic wait_for_quiet();
      req_chan.valid <= 1'b0;
      while (pending_events.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // APB write: setup, access (write at the edge with pready), then idle
   task automatic write_register(input logic [1:0] index, input logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= {index, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (index)
         REG_HOLD_TIME:    cfg.hold_time_ms         = value;
         REG_REPEAT_HOLD:  cfg.repeat_hold_ms       = value;
         REG_MULTI_WINDOW: cfg.multiclick_window_ms = value;
         REG_BISTABLE:     cfg.bistable_mode        = value[0];
         default: ;
      endcase
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_settings(input logic [TIME_W-1:0] hold_ms, input logic [TIME_W-1:0] rep_ms,
                                 input logic [TIME_W-1:0] window_ms, input logic bistable);
      wait_for_quiet();
      write_register(REG_HOLD_TIME, hold_ms);
      write_register(REG_REPEAT_HOLD, rep_ms);
      write_register(REG_MULTI_WINDOW, window_ms);
      // upper bits are junk on purpose: only bit 0 is the mode
      write_register(REG_BISTABLE, ($urandom() & 32'hFFFF_FFFE) | 32'(bistable));
   endtask

   task automatic note_failure(input string msg);
      mismatch_count++;
      if (mismatch_count <= MAX_REPORTS)
         $display("MISMATCH at %0t: %s", $realtime, msg);
   endtask

   // ---------------------------------------------------------------------------
   // Result side: receiver stalls and event checking
   // ---------------------------------------------------------------------------
   initial begin : reply_side
      rsp_chan.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (holdoff_left > 0) begin
            rsp_chan.ready <= 1'b0;
            holdoff_left--;
         end else begin
            rsp_chan.ready <= ($urandom_range(99) >= reply_stall_pct);
         end
      end
   end

   // Values read right after the edge are the ones the transfer used
   always @(posedge clock) begin : check_events
      gesture_event_type want;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         if (pending_events.size() == 0) begin
            note_failure($sformatf("event_code %0d with no event expected",
                                   rsp_chan.event_code));
         end else begin
            want = pending_events.pop_front();
            if (rsp_chan.event_code !== want.code)
               note_failure($sformatf("event_code expected %0d, got %0d",
                                      want.code, rsp_chan.event_code));
            if (rsp_chan.last_of_run !== want.last_of_run)
               note_failure($sformatf("last_of_run expected %0b, got %0b (event %0d)",
                                      want.last_of_run, rsp_chan.last_of_run, want.code));
         end
      end
   end

   // Watchdog: any run that stops moving for too long is a failure
   initial begin : watchdog
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
             csr_psel)
            idle_cycles = 0;
         else
            idle_cycles++;
      end
      $display("button_gesture_classifier_top verification failed");
      $finish;
   end

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // Registers at reset value: only press/release/change, series dropped silently.
   // Time runs through the top of the 32-bit range and wraps to zero.
   task automatic test_reset_defaults();
      sim_ms = 32'hFFFF_FFFE;
      send_tick(1'b0, 0);            // same as reset level: nothing
      send_tick(1'b1, 1);            // press at all-ones time
      send_tick(1'b1, 1);            // time wraps to 0, hold disabled
      send_tick(1'b0, 0);            // release
      send_tick(1'b0, 5);            // window zero: silent clear
   endtask

   task automatic test_directed_gestures();
      apply_settings(10, 5, 20, 1'b0);
      // hold fires strictly after 10 ms, then every 5 ms
      send_tick(1'b1, 1);
      send_tick(1'b1, 10);           // elapsed 10: not yet
      send_tick(1'b1, 1);            // hold
      send_tick(1'b1, 5);            // elapsed 16 > 15: second hold
      send_tick(1'b1, 3);            // elapsed 19 < 20
      send_tick(1'b0, 11);
      send_tick(1'b0, 30);           // held series ends silently
      // double click, quiet tick exactly on the window edge first
      send_tick(1'b1, 1);
      send_tick(1'b0, 5);
      send_tick(1'b1, 5);
      send_tick(1'b0, 5);
      send_tick(1'b0, 20);
      send_tick(1'b0, 1);            // click_2
      // repeat interval zero: one hold only
      apply_settings(10, 0, 20, 1'b0);
      send_tick(1'b1, 1);
      send_tick(1'b1, 11);
      send_tick(1'b1, 40);
      send_tick(1'b0, 1);
      send_tick(1'b0, 25);
      // bistable: every change counts, no hold
      apply_settings(10, 5, 20, 1'b1);
      send_tick(1'b1, 1);
      send_tick(1'b0, 3);
      send_tick(1'b0, 21);           // click_2
      send_tick(1'b1, 1);
      send_tick(1'b1, 50);           // click_1 while still pressed
      // window zero does not block hold
      apply_settings(10, 5, 0, 1'b0);
      send_tick(1'b1, 1);
      send_tick(1'b1, 11);
      send_tick(1'b0, 1);
      send_tick(1'b0, 1);
   endtask

   task automatic test_threshold_extremes();
      // second threshold lands past 2^32 and must never fire
      apply_settings(32'hFFFF_FFF0, 32'h20, 32'hFFFF_FFFF, 1'b0);
      send_tick(1'b1, 1);
      send_tick(1'b1, 32'hFFFF_FFF5);
      send_tick(1'b1, 10);           // elapsed all-ones
      send_tick(1'b0, 1);
      send_tick(1'b0, 32'hFFFF_FFFF); // not beyond an all-ones window
      // all-ones hold is unreachable; shortest window
      apply_settings(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1, 1'b0);
      send_tick(1'b0, 2);            // leftover held series stays open: elapsed equals the window
      send_tick(1'b1, 1);
      send_tick(1'b1, 32'hFFFF_FFFF);
      send_tick(1'b0, 1);
      send_tick(1'b0, 2);            // leftover held series ends silently
      // minimum nonzero settings
      apply_settings(1, 1, 1, 1'b0);
      send_tick(1'b1, 1);
      send_tick(1'b1, 1);
      send_tick(1'b1, 1);            // hold
      send_tick(1'b1, 1);            // hold
      send_tick(1'b1, 0);            // elapsed equals threshold
      send_tick(1'b0, 1);
      send_tick(1'b0, 2);
   endtask

   // 257 presses: count sticks at 255, so no hold and only crazy_clicker
   task automatic test_click_saturation();
      apply_settings(5, 0, 1000, 1'b0);
      send_tick(1'b0, 2000);
      repeat (256) begin
         send_tick(1'b1, 1);
         send_tick(1'b0, 1);
      end
      send_tick(1'b1, 1);
      send_tick(1'b1, 100);          // many clicks: no hold
      send_tick(1'b0, 1);
      send_tick(1'b0, 1001);
   endtask

   // Receiver holds off while two-event ticks keep coming: queue fills and
   // req_chan.ready must drop without losing anything.
   task automatic test_backpressure();
      apply_settings(20, 5, 15, 1'b0);
      sender_idle_pct = 0;
      reply_stall_pct = 0;
      holdoff_left    = 300;
      repeat (40) send_tick(!seen_level, 1);
   endtask

   task automatic random_settings();
      case ($urandom_range(9))
         0: apply_settings($urandom_range(1, 40), $urandom_range(0, 15), 0, 1'b0);
         1: apply_settings($urandom_range(1, 40), $urandom_range(1, 15),
                           $urandom_range(1, 30), 1'b1);
         2: apply_settings($urandom_range(1, 40), 0, $urandom_range(1, 40), 1'b0);
         3: apply_settings($urandom_range(1) ? 32'hFFFF_FFFF : 32'd1,
                           $urandom_range(1) ? 32'hFFFF_FFFF : 32'd1,
                           $urandom_range(1) ? 32'hFFFF_FFFF : 32'd1,
                           1'($urandom_range(1)));
         4: apply_settings(0, $urandom_range(0, 15), $urandom_range(1, 40), 1'b0);
         default: apply_settings($urandom_range(1, 40), $urandom_range(1, 15),
                                 $urandom_range(1, 40), 1'b0);
      endcase
   endtask

   // Well-formed series: quick presses, optional hold on the last one, then a
   // quiet tick around the window edge.
   task automatic play_gesture();
      int unsigned clicks, held_ticks, win_cap, hold_cap;
      win_cap  = (cfg.multiclick_window_ms == 0 || cfg.multiclick_window_ms > 40) ?
                 8 : cfg.multiclick_window_ms;
      hold_cap = (cfg.hold_time_ms == 0 || cfg.hold_time_ms > 40) ? 10 : cfg.hold_time_ms;
      clicks     = ($urandom_range(99) < 20) ? $urandom_range(9, 13) : $urandom_range(1, 4);
      held_ticks = ($urandom_range(2) == 0) ? $urandom_range(1, 6) : 0;
      for (int i = 1; i <= clicks; i++) begin
         send_tick(1'b1, $urandom_range(1, win_cap));
         if (i == clicks)
            repeat (held_ticks) send_tick(1'b1, $urandom_range(1, hold_cap));
         send_tick(1'b0, $urandom_range(1, win_cap));
      end
      send_tick(1'b0, cfg.multiclick_window_ms + $urandom_range(0, 3));
   endtask

   // Noise: random levels, small steps and wild jumps in time
   task automatic play_noise();
      int unsigned n;
      logic [TIME_W-1:0] step;
      n = $urandom_range(1, 6);
      repeat (n) begin
         case ($urandom_range(9))
            0, 1:    step = $urandom();
            2, 3, 4: step = $urandom_range(0, 100);
            default: step = $urandom_range(0, 5);
         endcase
         send_tick(1'($urandom_range(1)), step);
      end
   endtask

   task automatic test_random_traffic();
      int idle_mix[4][2] = '{'{0, 0}, '{62, 0}, '{0, 62}, '{25, 25}};
      int unsigned start;
      for (int p = 0; p < 4; p++) begin
         sender_idle_pct = idle_mix[p][0];
         reply_stall_pct = idle_mix[p][1];
         repeat (3) begin
            random_settings();
            start = ticks_sent;
            while (ticks_sent - start < 100) begin
               if ($urandom_range(99) < 80)
                  play_gesture();
               else
                  play_noise();
            end
         end
      end
   endtask

   // ---------------------------------------------------------------------------
   // Main sequence
   // ---------------------------------------------------------------------------
   initial begin
      reset                  <= 1'b1;
      req_chan.valid         <= 1'b0;
      req_chan.level_pressed <= 1'b0;
      req_chan.now_ms        <= '0;
      csr_psel               <= 1'b0;
      csr_penable            <= 1'b0;
      csr_pwrite             <= 1'b0;
      csr_paddr              <= '0;
      csr_pwdata             <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_reset_defaults();
      test_directed_gestures();
      test_threshold_extremes();
      test_click_saturation();
      test_backpressure();
      test_random_traffic();

      // drain, then a margin in which no stray event may appear
      wait_for_quiet();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pending_events.size() == 0) begin
         $display("button_gesture_classifier_top verification clean");
      end else begin
         $display("button_gesture_classifier_top verification failed");
      end
      $finish;
   end

endmodule
